>>> hw/rtl/mf3_pkg.sv
// Shared types, constants and the 3x3 median function for the RGB median filter.
`timescale 1ns / 1ps
package mf3_pkg;
  localparam int MaxWidthDef = 2048;
  localparam logic [11:0] WidthReset = 12'd640;
  localparam logic [15:0] HeightReset = 16'd480;
  localparam logic CfgIdxWidth = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdDrain = 1'b1;

  typedef logic [23:0] pix_t;

  // Work item handed from the front part to the back part.
  typedef struct packed {
    logic emit_pend;   // emit row-end output from the old window first
    logic emit_pend_last;
    logic load_col0;   // fill the whole window with the new column
    logic emit_new;    // emit after shifting in the new column
    logic ld_new;      // any new column at all
    pix_t t;
    pix_t m;
    pix_t b;
  } mf3_op_t;

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) med3 = lo;
    else if (c >= hi) med3 = hi;
    else med3 = c;
  endfunction

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] x;
    x = (a > b) ? a : b;
    max3 = (x > c) ? x : c;
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] x;
    x = (a < b) ? a : b;
    min3 = (x < c) ? x : c;
  endfunction

  // Classic column sort / row select median of nine.
  function automatic logic [7:0] med9(input logic [71:0] v);
    logic [7:0] a0, a1, a2, b0, b1, b2, c0, c1, c2;
    a0 = min3(v[7:0], v[15:8], v[23:16]);
    a1 = med3(v[7:0], v[15:8], v[23:16]);
    a2 = max3(v[7:0], v[15:8], v[23:16]);
    b0 = min3(v[31:24], v[39:32], v[47:40]);
    b1 = med3(v[31:24], v[39:32], v[47:40]);
    b2 = max3(v[31:24], v[39:32], v[47:40]);
    c0 = min3(v[55:48], v[63:56], v[71:64]);
    c1 = med3(v[55:48], v[63:56], v[71:64]);
    c2 = max3(v[55:48], v[63:56], v[71:64]);
    med9 = med3(max3(a0, b0, c0), med3(a1, b1, c1), min3(a2, b2, c2));
  endfunction
endpackage

>>> hw/rtl/mf3_front.sv
// Front part: position tracking, line buffers and classification of each item.
`timescale 1ns / 1ps
module mf3_front #(
  parameter int MAX_WIDTH = mf3_pkg::MaxWidthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  input  logic cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  input  logic in_cmd,
  input  mf3_pkg::pix_t in_pix,
  output logic in_ready,
  output logic op_valid,
  output mf3_pkg::mf3_op_t op,
  input  logic op_ready
);
  import mf3_pkg::*;
  localparam int AW = $clog2(MAX_WIDTH);

  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [AW-1:0] col_r;
  logic [15:0] row_r;
  logic pending_r, tail_r;
  pix_t above_mem [MAX_WIDTH];
  pix_t cur_mem [MAX_WIDTH];

  // stage 1: memory read
  logic s1_v_r, s1_drain_r, s1_r0_r, s1_r2_r, s1_col0_r, s1_pend_r, s1_tail_r;
  logic s1_emitn_r;
  pix_t s1_pix_r, s1_above_r, s1_cur_r;

  logic [13:0] w_eff;
  logic [15:0] h_eff;
  logic drain, take, act, last_col, pend_now;

  always_comb begin
    if (width_r == 12'd0) w_eff = 14'd1;
    else if ({2'b0, width_r} > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
    else w_eff = {2'b0, width_r};
    h_eff = (height_r == 16'd0) ? 16'd1 : height_r;
  end

  assign in_ready = !s1_v_r || op_ready;
  assign take = in_valid && in_ready;
  assign drain = row_r >= h_eff;
  // early drain tick does nothing
  assign act = take && (tail_r || drain || in_cmd == CmdPixel);
  assign pend_now = (col_r == '0) && pending_r;
  assign last_col = ({{(14 - AW){1'b0}}, col_r} + 14'd1) >= w_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WidthReset;
      height_r <= HeightReset;
      col_r <= '0;
      row_r <= '0;
      pending_r <= 1'b0;
      tail_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CfgIdxWidth) width_r <= cfg_data[11:0];
        else height_r <= cfg_data[15:0];
      end
      if (in_ready) s1_v_r <= act;
      if (act) begin
        if (tail_r) begin
          col_r <= '0;
          row_r <= '0;
          pending_r <= 1'b0;
          tail_r <= 1'b0;
        end else begin
          if (last_col && row_r != 16'd0) pending_r <= 1'b1;
          else if (pend_now) pending_r <= 1'b0;
          if (last_col) begin
            col_r <= '0;
            if (drain) tail_r <= 1'b1;
            else row_r <= row_r + 16'd1;
          end else begin
            col_r <= col_r + {{(AW - 1){1'b0}}, 1'b1};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      s1_above_r <= above_mem[col_r];
      s1_cur_r <= cur_mem[col_r];
      if (!tail_r && !drain) begin
        above_mem[col_r] <= cur_mem[col_r];
        cur_mem[col_r] <= in_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && act) begin
      s1_drain_r <= drain;
      s1_r0_r <= row_r == 16'd0;
      s1_r2_r <= row_r >= 16'd2;
      s1_col0_r <= col_r == '0;
      s1_pend_r <= tail_r || pend_now;
      s1_tail_r <= tail_r;
      s1_emitn_r <= !tail_r && col_r != '0 && row_r != 16'd0 && !pend_now;
      s1_pix_r <= in_pix;
    end
  end

  always_comb begin
    op_valid = s1_v_r;
    op.emit_pend = s1_pend_r;
    op.emit_pend_last = s1_tail_r;
    op.ld_new = !s1_tail_r;
    op.load_col0 = s1_col0_r;
    op.emit_new = s1_emitn_r;
    if (s1_r0_r) begin
      op.t = s1_pix_r;
      op.m = s1_pix_r;
      op.b = s1_pix_r;
    end else begin
      op.m = s1_cur_r;
      op.t = s1_r2_r ? s1_above_r : s1_cur_r;
      op.b = s1_drain_r ? s1_cur_r : s1_pix_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    tail_r |-> col_r == '0) else $error("tail with nonzero column");
  assert property (@(posedge clk) disable iff (!rst_n)
    (act && tail_r) |=> (row_r == 16'd0 && !pending_r))
    else $error("frame not restarted after tail");
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !op_ready) |=> s1_v_r) else $error("stage dropped item");
endmodule

>>> hw/rtl/mf3_back.sv
// Back part: 3x3 window register, median of each channel and the result queue.
`timescale 1ns / 1ps
module mf3_back (
  input  logic clk,
  input  logic rst_n,
  input  logic op_valid,
  input  mf3_pkg::mf3_op_t op,
  output logic op_ready,
  output logic out_empty,
  input  logic out_pop,
  output logic [7:0] out_chan0_out,
  output logic [7:0] out_chan1_out,
  output logic [7:0] out_chan2_out,
  output logic out_frame_end
);
  import mf3_pkg::*;
  localparam int QD = 4;

  pix_t win_r [9];
  pix_t win_nxt [9];
  pix_t mid [9];
  logic [24:0] res_q_r [QD];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  // registered median stage
  logic ev_r, el_r;
  pix_t mw_r [9];
  logic [2:0] ev_cnt;
  logic e_any, e_last, take;
  logic [24:0] res;

  // worst case two stage items plus two queued: need room for two
  assign ev_cnt = {2'b0, ev_r};
  assign op_ready = (cnt_r + ev_cnt) <= 3'(QD - 2);
  assign take = op_valid && op_ready;

  always_comb begin
    for (int i = 0; i < 6; i++) mid[i] = win_r[i + 3];
    mid[6] = win_r[6];
    mid[7] = win_r[7];
    mid[8] = win_r[8];
    for (int i = 0; i < 9; i++) win_nxt[i] = op.emit_pend ? mid[i] : win_r[i];
    if (op.ld_new) begin
      if (op.load_col0) begin
        for (int k = 0; k < 3; k++) begin
          win_nxt[k * 3] = op.t;
          win_nxt[k * 3 + 1] = op.m;
          win_nxt[k * 3 + 2] = op.b;
        end
      end else begin
        for (int i = 0; i < 6; i++) win_nxt[i] = win_nxt[i + 3];
        win_nxt[6] = op.t;
        win_nxt[7] = op.m;
        win_nxt[8] = op.b;
      end
    end
  end

  // at most one emit per item: row-end flush emits the shifted old window
  assign e_any = op.emit_pend || op.emit_new;
  assign e_last = op.emit_pend_last;

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
      for (int i = 0; i < 9; i++) mw_r[i] <= op.emit_pend ? mid[i] : win_nxt[i];
      el_r <= e_last;
    end
  end

  always_comb begin
    logic [71:0] v0, v1, v2;
    for (int i = 0; i < 9; i++) begin
      v0[i*8 +: 8] = mw_r[i][7:0];
      v1[i*8 +: 8] = mw_r[i][15:8];
      v2[i*8 +: 8] = mw_r[i][23:16];
    end
    res = {el_r, med9(v2), med9(v1), med9(v0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      ev_r <= take && e_any;
      if (ev_r) wp_r <= wp_r + 2'd1;
      if (out_pop && !out_empty) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, ev_r} - {2'b0, out_pop && !out_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (ev_r) res_q_r[wp_r] <= res;
  end

  assign out_empty = cnt_r == 3'd0;
  assign {out_frame_end, out_chan2_out, out_chan1_out, out_chan0_out} = res_q_r[rp_r];

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QD)) else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'(QD)) |-> !op_ready) else $error("ready while queue full");
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && e_any) |=> ev_r) else $error("emit lost");
endmodule

>>> hw/rtl/median3x3_filter_rgb.sv
// Top level of the streaming 3x3 RGB median filter.
// A result passes the front stage register, the median stage register and the result queue.
// Throughput: one item per cycle while the result queue has room; outputs trail input by one row plus one pixel.
// After the frame, image_width + 1 drain items flush the remaining results.
// Reset (synchronous, rst_n low): counters and queue clear, registers return to
// 640 x 480; line buffers hold stale data and need no clearing.
`timescale 1ns / 1ps
module median3x3_filter_rgb #(
  parameter int MAX_WIDTH = mf3_pkg::MaxWidthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_push,
  output logic in_full,
  input  logic in_cmd,
  input  logic [7:0] in_chan0_in,
  input  logic [7:0] in_chan1_in,
  input  logic [7:0] in_chan2_in,
  output logic out_empty,
  input  logic out_pop,
  output logic [7:0] out_chan0_out,
  output logic [7:0] out_chan1_out,
  output logic [7:0] out_chan2_out,
  output logic out_frame_end
);
  import mf3_pkg::*;
  logic in_ready, op_valid, op_ready;
  mf3_op_t op;

  assign cfg_ready = 1'b1;
  assign in_full = !in_ready;

  mf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .in_valid(in_push), .in_cmd, .in_pix({in_chan2_in, in_chan1_in, in_chan0_in}),
    .in_ready, .op_valid, .op, .op_ready
  );

  mf3_back u_back (
    .clk, .rst_n, .op_valid, .op, .op_ready, .out_empty, .out_pop,
    .out_chan0_out, .out_chan1_out, .out_chan2_out, .out_frame_end
  );
endmodule
